/* rtl/unwf_pkg.sv */
// Shared types, constants and the suffix lookup for the URI name whitelist filter.
// Used by the channel interfaces and the top level; depends on nothing.
package unwf_pkg;

  // Widths of the request and verdict fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TAIL_W   = 40;

  localparam logic [BYTE_W-1:0] MAX_NAME_LENGTH = 8'd31;
  localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'd255;

  // Characters with a fixed role
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_NAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TYPE        = 2'd2;

  // Parse phase of the current URI
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_NAME  = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  // Verdict reason
  typedef enum logic [REASON_W-1:0] {
    RSN_OK         = 3'd0,
    RSN_NO_BUFFER  = 3'd1,
    RSN_NO_SLASH   = 3'd2,
    RSN_TOO_LONG   = 3'd3,
    RSN_BAD_CHAR   = 3'd4,
    RSN_LEAD_DOT   = 3'd5,
    RSN_NOT_SERVED = 3'd6
  } reason_t;

  // Content types; the suffix table below is in the same order
  localparam int unsigned SUFFIX_COUNT = 7;
  localparam logic [TYPE_W-1:0] TYPE_HTML = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_NONE = 3'd7;

  typedef logic [TAIL_W-1:0] tail_t;

  // Suffix text right-aligned to the newest byte of the tail
  localparam tail_t SUFFIX_TEXT [SUFFIX_COUNT] = '{
    40'(".html"), 40'(".css"), 40'(".js"), 40'(".png"),
    40'(".ico"), 40'(".svg"), 40'(".txt")
  };
  localparam logic [2:0] SUFFIX_LEN [SUFFIX_COUNT] = '{
    3'd5, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // Byte allowed in a served name: letter, digit, '.', '_' or '-'
  function automatic logic byte_allowed(input logic [BYTE_W-1:0] c);
    byte_allowed = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == CH_UNDER ||
                   c == CH_DASH;
  endfunction

  // First suffix that ends the tail and is strictly shorter than the name
  function automatic logic [TYPE_W-1:0] match_suffix(input tail_t tail,
                                                     input logic [BYTE_W-1:0] len);
    tail_t mask;
    logic [TYPE_W-1:0] found;
    found = TYPE_NONE;
    for (int s = SUFFIX_COUNT - 1; s >= 0; s--) begin
      mask = ~(tail_t'('1) << (8 * SUFFIX_LEN[s]));
      if ({5'd0, SUFFIX_LEN[s]} < len && (tail & mask) == SUFFIX_TEXT[s]) begin
        found = TYPE_W'(s);
      end
    end
    return found;
  endfunction

endpackage

/* rtl/unwf_in_if.sv */
// Request channel of the URI name whitelist filter: one URI byte per request.
// Depends on unwf_pkg for field widths.
interface unwf_in_if;
  logic                           valid;
  logic                           ready;
  logic [unwf_pkg::BYTE_W-1:0]    uri_byte;

  modport source (output valid, output uri_byte, input ready);
  modport sink   (input valid, input uri_byte, output ready);
endinterface

// Verdict channel of the URI name whitelist filter: one verdict per URI.
// Depends on unwf_pkg for field widths.
interface unwf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [unwf_pkg::REASON_W-1:0]  reason_code;
  logic [unwf_pkg::TYPE_W-1:0]    type_code;
  logic [unwf_pkg::BYTE_W-1:0]    name_length;
  logic                           used_default;

  modport source (output valid, output accepted, output reason_code, output type_code,
                  output name_length, output used_default, input ready);
  modport sink   (input valid, input accepted, input reason_code, input type_code,
                  input name_length, input used_default, output ready);
endinterface

/* rtl/uri_name_whitelist_filter.sv */
// URI name whitelist filter: parses URI bytes and gives one verdict per URI.
// Latency: the verdict is valid the cycle after the terminating zero byte is taken.
// Throughput: one byte per cycle; a new byte is taken while a verdict waits,
// as long as the single verdict register is free or is drained in that cycle.
// Reset (synchronous, rst_n low): parse state cleared, no verdict pending,
// registers return to capacity 32, index name length 10, index type html.
// Depends on unwf_pkg, unwf_in_if and unwf_out_if.
module uri_name_whitelist_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  unwf_in_if.sink                          in_ch,
  unwf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [unwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [unwf_pkg::BYTE_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [unwf_pkg::BYTE_W-1:0] buf_cap_r;
  logic [unwf_pkg::BYTE_W-1:0] dflt_len_r;
  logic [unwf_pkg::TYPE_W-1:0] dflt_type_r;

  // Parse state
  unwf_pkg::phase_t            phase_r, phase_nxt;
  logic [unwf_pkg::BYTE_W-1:0] count_r, count_nxt;
  unwf_pkg::tail_t             tail_r, tail_nxt;
  logic                        bad_start_r, bad_start_nxt;
  logic                        bad_char_r, bad_char_nxt;
  logic                        first_dot_r, first_dot_nxt;

  // Verdict register
  logic                          out_valid_r, out_valid_nxt;
  logic                          accepted_r, accepted_nxt;
  unwf_pkg::reason_t             reason_r, reason_nxt;
  logic [unwf_pkg::TYPE_W-1:0]   type_r, type_nxt;
  logic [unwf_pkg::BYTE_W-1:0]   length_r, length_nxt;
  logic                          used_r, used_nxt;

  logic                          take;
  logic                          is_end;
  logic                          slash;
  logic [unwf_pkg::TYPE_W-1:0]   suffix_hit;

  // Take a request when the verdict register is empty or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_end      = (in_ch.uri_byte == unwf_pkg::CH_NUL);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = accepted_r;
  assign out_ch.reason_code  = reason_r;
  assign out_ch.type_code    = type_r;
  assign out_ch.name_length  = length_r;
  assign out_ch.used_default = used_r;

  // Hold configuration; write by index, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cap_r   <= 8'd32;
      dflt_len_r  <= 8'd10;
      dflt_type_r <= unwf_pkg::TYPE_HTML;
    end else if (cfg_we) begin
      unique case (cfg_index)
        unwf_pkg::CFG_BUFFER_CAPACITY:     buf_cap_r   <= cfg_wdata;
        unwf_pkg::CFG_DEFAULT_NAME_LENGTH: dflt_len_r  <= cfg_wdata;
        unwf_pkg::CFG_DEFAULT_TYPE:        dflt_type_r <= cfg_wdata[unwf_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the parse state and form the verdict
  assign slash      = (phase_r != unwf_pkg::PH_FIRST) && !bad_start_r;
  assign suffix_hit = unwf_pkg::match_suffix(tail_r, count_r);

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    tail_nxt      = tail_r;
    bad_start_nxt = bad_start_r;
    bad_char_nxt  = bad_char_r;
    first_dot_nxt = first_dot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    accepted_nxt  = accepted_r;
    reason_nxt    = reason_r;
    type_nxt      = type_r;
    length_nxt    = length_r;
    used_nxt      = used_r;

    if (take && !is_end) begin
      unique case (phase_r)
        unwf_pkg::PH_FIRST: begin
          if (in_ch.uri_byte == unwf_pkg::CH_SLASH) begin
            phase_nxt = unwf_pkg::PH_NAME;
          end else begin
            bad_start_nxt = 1'b1;
            phase_nxt     = unwf_pkg::PH_SKIP;
          end
        end
        unwf_pkg::PH_NAME: begin
          if (in_ch.uri_byte == unwf_pkg::CH_QUERY || in_ch.uri_byte == unwf_pkg::CH_HASH) begin
            phase_nxt = unwf_pkg::PH_SKIP;
          end else begin
            if (count_r == '0 && in_ch.uri_byte == unwf_pkg::CH_DOT) begin
              first_dot_nxt = 1'b1;
            end
            if (!unwf_pkg::byte_allowed(in_ch.uri_byte)) begin
              bad_char_nxt = 1'b1;
            end
            if (count_r != unwf_pkg::COUNT_MAX) begin
              count_nxt = count_r + 8'd1;
            end
            tail_nxt = {tail_r[unwf_pkg::TAIL_W-unwf_pkg::BYTE_W-1:0], in_ch.uri_byte};
          end
        end
        default: ;  // skip the rest of the URI
      endcase
    end else if (take) begin
      // End of URI: load the verdict and clear the parse state
      out_valid_nxt = 1'b1;
      accepted_nxt  = 1'b0;
      type_nxt      = unwf_pkg::TYPE_HTML;
      used_nxt      = slash && (count_r == '0);
      if (!slash) begin
        length_nxt = '0;
      end else if (count_r == '0) begin
        length_nxt = dflt_len_r;
      end else begin
        length_nxt = count_r;
      end

      priority if (buf_cap_r == '0) begin
        reason_nxt = unwf_pkg::RSN_NO_BUFFER;
      end else if (!slash) begin
        reason_nxt = unwf_pkg::RSN_NO_SLASH;
      end else if (length_nxt > unwf_pkg::MAX_NAME_LENGTH || length_nxt >= buf_cap_r) begin
        reason_nxt = unwf_pkg::RSN_TOO_LONG;
      end else if (used_nxt) begin
        reason_nxt   = unwf_pkg::RSN_OK;
        accepted_nxt = 1'b1;
        type_nxt     = dflt_type_r;
      end else if (bad_char_r) begin
        reason_nxt = unwf_pkg::RSN_BAD_CHAR;
      end else if (first_dot_r) begin
        reason_nxt = unwf_pkg::RSN_LEAD_DOT;
      end else if (suffix_hit == unwf_pkg::TYPE_NONE) begin
        reason_nxt = unwf_pkg::RSN_NOT_SERVED;
      end else begin
        reason_nxt   = unwf_pkg::RSN_OK;
        accepted_nxt = 1'b1;
        type_nxt     = suffix_hit;
      end

      phase_nxt     = unwf_pkg::PH_FIRST;
      count_nxt     = '0;
      tail_nxt      = '0;
      bad_start_nxt = 1'b0;
      bad_char_nxt  = 1'b0;
      first_dot_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= unwf_pkg::PH_FIRST;
      count_r     <= '0;
      tail_r      <= '0;
      bad_start_r <= 1'b0;
      bad_char_r  <= 1'b0;
      first_dot_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      tail_r      <= tail_nxt;
      bad_start_r <= bad_start_nxt;
      bad_char_r  <= bad_char_nxt;
      first_dot_r <= first_dot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verdict payload
  always_ff @(posedge clk) begin
    accepted_r <= accepted_nxt;
    reason_r   <= reason_nxt;
    type_r     <= type_nxt;
    length_r   <= length_nxt;
    used_r     <= used_nxt;
  end

endmodule

/* sim/unwf_verdict_board.sv */
// Verdict predictor and scoreboard for the URI name whitelist filter testbench.
// Keeps its own copy of the registers and the parse state; depends on unwf_pkg.
package unwf_verdict_board_pkg;
  import unwf_pkg::*;

  // Type field of a refused name
  localparam logic [TYPE_W-1:0] TYPE_REFUSED = '0;

  typedef struct {
    logic                accepted;
    logic [REASON_W-1:0] reason;
    logic [TYPE_W-1:0]   ctype;
    logic [BYTE_W-1:0]   length;
    logic                used;
  } verdict_t;

  class verdict_board;
    logic [BYTE_W-1:0] capacity;
    logic [BYTE_W-1:0] index_len;
    logic [TYPE_W-1:0] index_type;
    phase_t            phase;
    logic [BYTE_W-1:0] count;
    tail_t             tail;
    bit                bad_start;
    bit                bad_char;
    bit                lead_dot;
    verdict_t          expected[$];
    int                errors;

    function new();
      capacity   = 8'd32;
      index_len  = 8'd10;
      index_type = TYPE_HTML;
      errors     = 0;
      clear_uri();
    endfunction

    static function bit is_name_char(logic [BYTE_W-1:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
             c == CH_DOT || c == CH_UNDER || c == CH_DASH;
    endfunction

    function void clear_uri();
      phase     = PH_FIRST;
      count     = '0;
      tail      = '0;
      bad_start = 0;
      bad_char  = 0;
      lead_dot  = 0;
    endfunction

    // Ignore indexes past the last register
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      case (idx)
        CFG_BUFFER_CAPACITY:     capacity = data;
        CFG_DEFAULT_NAME_LENGTH: index_len = data;
        CFG_DEFAULT_TYPE:        index_type = data[TYPE_W-1:0];
        default: ;
      endcase
    endfunction

    // First extension, with its dot, that ends the tail and is shorter than the name
    function logic [TYPE_W-1:0] suffix_type();
      string exts[SUFFIX_COUNT] = '{"html", "css", "js", "png", "ico", "svg", "txt"};
      logic [63:0] pattern;
      int n;
      for (int s = 0; s < SUFFIX_COUNT; s++) begin
        pattern = 64'(CH_DOT);
        for (int k = 0; k < exts[s].len(); k++) begin
          pattern = (pattern << 8) | 64'(exts[s][k]);
        end
        n = exts[s].len() + 1;
        if (n < int'(count) && (64'(tail) & ((64'd1 << (8 * n)) - 1)) == pattern) begin
          return TYPE_W'(s);
        end
      end
      return TYPE_NONE;
    endfunction

    // Advance the parse state on one request; a zero byte yields the verdict
    function void note_byte(logic [BYTE_W-1:0] b);
      verdict_t v;
      bit slash;
      if (b != CH_NUL) begin
        case (phase)
          PH_FIRST: begin
            if (b == CH_SLASH) begin
              phase = PH_NAME;
            end else begin
              bad_start = 1;
              phase = PH_SKIP;
            end
          end
          PH_NAME: begin
            if (b == CH_QUERY || b == CH_HASH) begin
              phase = PH_SKIP;
            end else begin
              if (count == 0 && b == CH_DOT) lead_dot = 1;
              if (!is_name_char(b)) bad_char = 1;
              if (count != COUNT_MAX) count++;
              tail = {tail[TAIL_W-BYTE_W-1:0], b};
            end
          end
          default: ;
        endcase
        return;
      end

      v.accepted = 0;
      v.reason   = RSN_OK;
      v.ctype    = TYPE_REFUSED;
      v.length   = '0;
      v.used     = 0;
      slash = (phase != PH_FIRST) && !bad_start;
      if (slash) begin
        v.used   = (count == 0);
        v.length = v.used ? index_len : count;
      end
      if (capacity == 0) begin
        v.reason = RSN_NO_BUFFER;
      end else if (!slash) begin
        v.reason = RSN_NO_SLASH;
      end else if (v.length > MAX_NAME_LENGTH || int'(v.length) + 1 > int'(capacity)) begin
        v.reason = RSN_TOO_LONG;
      end else if (v.used) begin
        v.accepted = 1;
        v.ctype    = index_type;
      end else if (bad_char) begin
        v.reason = RSN_BAD_CHAR;
      end else if (lead_dot) begin
        v.reason = RSN_LEAD_DOT;
      end else begin
        v.ctype = suffix_type();
        if (v.ctype == TYPE_NONE) begin
          v.reason = RSN_NOT_SERVED;
          v.ctype  = TYPE_REFUSED;
        end else begin
          v.accepted = 1;
        end
      end
      expected.push_back(v);
      clear_uri();
    endfunction

    function void compare(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Match a verdict against the oldest pending URI
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected.size() == 0) begin
        $error("verdict with no URI pending: reason_code %0d", got.reason);
        errors++;
        return;
      end
      want = expected.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("reason_code", want.reason, got.reason);
      compare("type_code", want.ctype, got.ctype);
      compare("name_length", want.length, got.length);
      compare("used_default", want.used, got.used);
    endfunction
  endclass

endpackage

/* sim/tb_uri_name_whitelist_filter.sv */
// Top testbench of the URI name whitelist filter: feeds directed and random URIs
// under random stalls and register settings. Depends on unwf_pkg, the channel
// interfaces, the block and unwf_verdict_board_pkg.
module tb_uri_name_whitelist_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import unwf_pkg::*;
  import unwf_verdict_board_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 145;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  unwf_in_if  in_if ();
  unwf_out_if out_if ();

  verdict_board      board = new();
  logic [BYTE_W-1:0] uri_bytes[$];
  bit                steady;
  bit                hold_req;
  int                stall;

  uri_name_whitelist_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive verdict ready; hold off for a long stretch when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || $urandom_range(99) >= 35;
      end
    end
  end

  // Check each accepted verdict
  always @(posedge clk) begin : take_verdict
    verdict_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.accepted = out_if.accepted;
      got.reason   = out_if.reason_code;
      got.ctype    = out_if.type_code;
      got.length   = out_if.name_length;
      got.used     = out_if.used_default;
      board.check_verdict(got);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall = 0;
      else stall++;
    end
    $display("tb_uri_name_whitelist_filter: errors");
    $finish;
  end

  task automatic add_uri(string s);
    for (int k = 0; k < s.len(); k++) uri_bytes.push_back(s[k]);
    uri_bytes.push_back(CH_NUL);
  endtask

  task automatic push_junk(int n);
    repeat (n) uri_bytes.push_back(BYTE_W'($urandom_range(255, 1)));
  endtask

  // Build '/' + stem + optional extension + optional query or fragment + zero
  task automatic add_name_uri(int stem_len, bit with_ext);
    string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";
    string exts[13] = '{".html", ".css", ".js", ".png", ".ico", ".svg", ".txt",
                        ".TXT", ".jpg", ".htm", "js", ".cs", ""};
    logic [BYTE_W-1:0] c;
    int tail_kind;
    uri_bytes.push_back(CH_SLASH);
    for (int k = 0; k < stem_len; k++) begin
      c = name_chars[$urandom_range(name_chars.len() - 1)];
      if (k == 0 && $urandom_range(7) == 0) c = CH_DOT;
      if ($urandom_range(39) == 0) begin
        do c = BYTE_W'($urandom_range(255, 1));
        while (verdict_board::is_name_char(c) || c == CH_QUERY || c == CH_HASH);
      end
      uri_bytes.push_back(c);
    end
    if (with_ext) begin
      string ext;
      ext = ($urandom_range(9) < 7) ? exts[$urandom_range(6)] : exts[$urandom_range(12, 7)];
      for (int k = 0; k < ext.len(); k++) uri_bytes.push_back(ext[k]);
    end
    tail_kind = $urandom_range(3);
    if (tail_kind == 0) begin
      uri_bytes.push_back(CH_QUERY);
      push_junk($urandom_range(8));
    end else if (tail_kind == 1) begin
      uri_bytes.push_back(CH_HASH);
      push_junk($urandom_range(8));
    end
    uri_bytes.push_back(CH_NUL);
  endtask

  // Mostly well-formed paths, with empty, unslashed and garbage URIs mixed in
  task automatic add_random_uri();
    int kind;
    logic [BYTE_W-1:0] c;
    kind = $urandom_range(99);
    if (kind < 4) begin
      uri_bytes.push_back(CH_NUL);
    end else if (kind < 12) begin
      do c = BYTE_W'($urandom_range(255, 1));
      while (c == CH_SLASH);
      uri_bytes.push_back(c);
      push_junk($urandom_range(6));
      uri_bytes.push_back(CH_NUL);
    end else if (kind < 18) begin
      if ($urandom_range(1)) uri_bytes.push_back(CH_SLASH);
      push_junk($urandom_range(20, 1));
      uri_bytes.push_back(CH_NUL);
    end else if (kind < 28) begin
      add_name_uri(0, $urandom_range(3) == 0);
    end else if (kind < 40) begin
      add_name_uri($urandom_range(34, 12), 1);
    end else if (kind == 40) begin
      add_name_uri($urandom_range(290, 250), 1);
    end else begin
      add_name_uri($urandom_range(10, 1), 1);
    end
  endtask

  // Offer queued bytes one request at a time, idling at random
  task automatic send_bytes();
    logic [BYTE_W-1:0] byte_now;
    while (uri_bytes.size() > 0) begin
      @(negedge clk);
      if (!steady && $urandom_range(99) < 35) begin
        in_if.valid    <= 1'b0;
        in_if.uri_byte <= BYTE_W'($urandom);
      end else begin
        byte_now = uri_bytes.pop_front();
        in_if.valid    <= 1'b1;
        in_if.uri_byte <= byte_now;
        do @(posedge clk);
        while (!in_if.ready);
        board.note_byte(byte_now);
      end
    end
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Wait for every verdict, then let the block go quiet
  task automatic settle();
    while (board.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [BYTE_W-1:0] cap, logic [BYTE_W-1:0] dlen,
                                logic [BYTE_W-1:0] dtype_raw);
    logic [CFG_IDX_W-1:0] regs[4];
    logic [BYTE_W-1:0]    vals[4];
    regs = '{CFG_BUFFER_CAPACITY, CFG_DEFAULT_NAME_LENGTH, CFG_DEFAULT_TYPE, CFG_UNUSED};
    vals = '{cap, dlen, dtype_raw, BYTE_W'($urandom)};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      board.write_reg(regs[k], vals[k]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] cap_set[PHASES];
    logic [BYTE_W-1:0] dlen_set[PHASES];
    logic [BYTE_W-1:0] dtype_set[PHASES];
    cap_set   = '{8'd255, 8'd1, 8'd0, 8'd32, 8'd20, 8'd0, 8'd33};
    dlen_set  = '{8'd255, 8'd1, 8'd30, 8'd0, 8'd31, 8'd0, 8'd32};
    dtype_set = '{8'd6, 8'd7, 8'd3, 8'hFD, 8'd2, 8'd0, 8'd1};
    cap_set[5]   = BYTE_W'($urandom_range(255, 1));
    dlen_set[5]  = BYTE_W'($urandom_range(255));
    dtype_set[5] = BYTE_W'($urandom_range(255));

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.uri_byte = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    steady         = 0;
    hold_req       = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty URI, no slash with high bytes, empty path, served name,
    // leading dot, query cut
    uri_bytes.push_back(CH_NUL);
    uri_bytes.push_back(8'hFF);
    uri_bytes.push_back(8'h80);
    uri_bytes.push_back(CH_NUL);
    add_uri("/");
    add_uri("/a.js");
    add_uri("/.js");
    add_uri("/x?y");
    send_bytes();
    settle();

    // Random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      apply_settings(cap_set[p], dlen_set[p], dtype_set[p]);
      steady = (p == 3);
      if (p == 4) hold_req = 1;
      if (p == 0) add_name_uri(270, 1);
      while (uri_bytes.size() < PHASE_BYTES) add_random_uri();
      send_bytes();
      settle();
    end
    steady = 0;

    if (board.errors == 0) begin
      $display("tb_uri_name_whitelist_filter: clean");
    end else begin
      $display("tb_uri_name_whitelist_filter: errors");
    end
    $finish;
  end

endmodule
